// ===== rtl/core/lmcs_pkg.sv =====
// shared types, constants and the microcode table of the led matrix column scanner
// used by every module under rtl/core; no dependencies of its own
`default_nettype none

package lmcs_pkg;

    // store geometry
    localparam int MAX_ROWS = 24;
    localparam int MAX_COLS = 16;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int CELL_W   = $clog2(CELLS);

    // field widths
    localparam int OPER_W = 3;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 4;
    localparam int INT_W  = 12;
    localparam int KIND_W = 2;
    localparam int CHAN_W = 5;
    localparam int DATA_W = 16;
    localparam int BITS_W = 5;
    localparam int CFG_W  = 5;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = OPER_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = KIND_W;
    localparam int S_PAD_W   = S_TDATA_W - ROW_W - COL_W - INT_W - 1;
    localparam int M_PAD_W   = M_TDATA_W - CHAN_W - DATA_W - BITS_W;

    // operations
    localparam logic [OPER_W-1:0] OP_SET_PIXEL  = 3'd0;
    localparam logic [OPER_W-1:0] OP_SET_ROW    = 3'd1;
    localparam logic [OPER_W-1:0] OP_SET_COLUMN = 3'd2;
    localparam logic [OPER_W-1:0] OP_SET_ALL    = 3'd3;
    localparam logic [OPER_W-1:0] OP_PRESENT    = 3'd4;
    localparam logic [OPER_W-1:0] OP_SCAN_TICK  = 3'd5;
    localparam logic [OPER_W-1:0] OP_READ_PIXEL = 3'd6;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CHAN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COLW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    // configuration register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    localparam logic [CFG_W-1:0] NUM_ROWS_RST = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] NUM_COLS_RST = CFG_W'(MAX_COLS);

    // column word
    localparam logic [CFG_W-1:0]  NARROW_COLS = 5'd8;
    localparam logic [BITS_W-1:0] COLW_NARROW = 5'd8;
    localparam logic [BITS_W-1:0] COLW_WIDE   = 5'd16;
    localparam logic [DATA_W-1:0] COLW_ONE    = 16'h0001;
    localparam logic [DATA_W-1:0] NARROW_MASK = 16'h00FF;
    localparam logic [DATA_W-1:0] WIDE_MASK   = 16'hFFFF;

    // microcode step addresses
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_IDLE = 5'd0;
    localparam logic [STEP_W-1:0] ST_CLR0 = 5'd1;
    localparam logic [STEP_W-1:0] ST_CLR1 = 5'd2;
    localparam logic [STEP_W-1:0] ST_PIX  = 5'd3;
    localparam logic [STEP_W-1:0] ST_ROW0 = 5'd4;
    localparam logic [STEP_W-1:0] ST_ROW1 = 5'd5;
    localparam logic [STEP_W-1:0] ST_COL0 = 5'd6;
    localparam logic [STEP_W-1:0] ST_COL1 = 5'd7;
    localparam logic [STEP_W-1:0] ST_ALL0 = 5'd8;
    localparam logic [STEP_W-1:0] ST_ALL1 = 5'd9;
    localparam logic [STEP_W-1:0] ST_ALL2 = 5'd10;
    localparam logic [STEP_W-1:0] ST_ALL3 = 5'd11;
    localparam logic [STEP_W-1:0] ST_PRS0 = 5'd12;
    localparam logic [STEP_W-1:0] ST_PRS1 = 5'd13;
    localparam logic [STEP_W-1:0] ST_PRS2 = 5'd14;
    localparam logic [STEP_W-1:0] ST_SCN0 = 5'd15;
    localparam logic [STEP_W-1:0] ST_SCN1 = 5'd16;
    localparam logic [STEP_W-1:0] ST_SCN2 = 5'd17;
    localparam logic [STEP_W-1:0] ST_SCN3 = 5'd18;
    localparam logic [STEP_W-1:0] ST_RD0  = 5'd19;
    localparam logic [STEP_W-1:0] ST_RD1  = 5'd20;

    typedef enum logic [2:0] {
        ROW_HOLD, ROW_ZERO, ROW_INC, ROW_DEC, ROW_TOP
    } row_op_t;

    typedef enum logic [1:0] {
        COL_HOLD, COL_ZERO, COL_INC
    } col_op_t;

    typedef enum logic [1:0] {
        LIN_HOLD, LIN_ZERO, LIN_INC
    } lin_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE, EMIT_CHAN, EMIT_COLW, EMIT_READ
    } emit_t;

    typedef enum logic [3:0] {
        C_NEVER, C_NO_ROWS, C_NO_COLS, C_NO_RC, C_ROW_MORE,
        C_COL_MORE, C_LIN_MORE, C_CHAN_MORE, C_PRESENT
    } cond_t;

    // one control word; all zero is a no-op
    typedef struct packed {
        row_op_t           row_op;
        col_op_t           col_op;
        lin_op_t           lin_op;
        logic              fr_we;
        logic              clr_we;
        logic              fr_rd_cell;
        logic              fr_rd_lin;
        logic              dr_rd;
        logic              chan_ld;
        emit_t             emit;
        logic              scol_adv;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              done;
    } ctrl_t;

    typedef struct packed {
        logic row_last;
        logic col_last;
        logic lin_last;
        logic chan_more;
        logic no_rows;
        logic no_cols;
        logic present;
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
    } scan_cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [COL_W-1:0] col_index;
        logic [INT_W-1:0] intensity;
        logic             present_after;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] channel;
        logic [DATA_W-1:0] data_word;
        logic [BITS_W-1:0] column_word_bits;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              fr_we;
        logic [CELL_W-1:0] fr_waddr;
        logic [INT_W-1:0]  fr_wdata;
        logic              fr_re;
        logic [CELL_W-1:0] fr_raddr;
        logic              dr_we;
        logic [CELL_W-1:0] dr_waddr;
        logic [INT_W-1:0]  dr_wdata;
        logic              dr_re;
        logic [CELL_W-1:0] dr_raddr;
    } store_req_t;

    // stores are column major
    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return CELL_W'(col * MAX_ROWS + row);
    endfunction

    function automatic logic [STEP_W-1:0] entry_step(input logic [OPER_W-1:0] op);
        logic [STEP_W-1:0] s;
        unique case (op)
            OP_SET_PIXEL:  s = ST_PIX;
            OP_SET_ROW:    s = ST_ROW0;
            OP_SET_COLUMN: s = ST_COL0;
            OP_SET_ALL:    s = ST_ALL0;
            OP_PRESENT:    s = ST_PRS0;
            OP_SCAN_TICK:  s = ST_SCN0;
            OP_READ_PIXEL: s = ST_RD0;
            default:       s = ST_IDLE;
        endcase
        return s;
    endfunction

    // microcode rom: next step is target if cond holds, else idle if done, else step + 1
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        unique case (step)
            ST_CLR0: w.lin_op = LIN_ZERO;
            ST_CLR1: begin
                w.clr_we = 1'b1;
                w.lin_op = LIN_INC;
                w.cond   = C_LIN_MORE;
                w.target = ST_CLR1;
                w.done   = 1'b1;
            end
            ST_PIX: begin
                w.fr_we = 1'b1;
                w.done  = 1'b1;
            end
            ST_ROW0: begin
                w.col_op = COL_ZERO;
                w.cond   = C_NO_COLS;
                w.target = ST_IDLE;
            end
            ST_ROW1: begin
                w.fr_we  = 1'b1;
                w.col_op = COL_INC;
                w.cond   = C_COL_MORE;
                w.target = ST_ROW1;
                w.done   = 1'b1;
            end
            ST_COL0: begin
                w.row_op = ROW_ZERO;
                w.cond   = C_NO_ROWS;
                w.target = ST_IDLE;
            end
            ST_COL1: begin
                w.fr_we  = 1'b1;
                w.row_op = ROW_INC;
                w.cond   = C_ROW_MORE;
                w.target = ST_COL1;
                w.done   = 1'b1;
            end
            ST_ALL0: begin
                w.row_op = ROW_ZERO;
                w.col_op = COL_ZERO;
                w.cond   = C_NO_RC;
                w.target = ST_ALL3;
            end
            ST_ALL1: begin
                w.fr_we  = 1'b1;
                w.row_op = ROW_INC;
                w.cond   = C_ROW_MORE;
                w.target = ST_ALL1;
            end
            ST_ALL2: begin
                w.row_op = ROW_ZERO;
                w.col_op = COL_INC;
                w.cond   = C_COL_MORE;
                w.target = ST_ALL1;
            end
            ST_ALL3: begin
                w.cond   = C_PRESENT;
                w.target = ST_PRS0;
                w.done   = 1'b1;
            end
            ST_PRS0: w.lin_op = LIN_ZERO;
            ST_PRS1: begin
                w.fr_rd_lin = 1'b1;
                w.lin_op    = LIN_INC;
                w.cond      = C_LIN_MORE;
                w.target    = ST_PRS1;
            end
            // lets the last drive write land before the next item
            ST_PRS2: w.done = 1'b1;
            ST_SCN0: begin
                w.row_op = ROW_TOP;
                w.cond   = C_NO_ROWS;
                w.target = ST_SCN3;
            end
            ST_SCN1: begin
                w.dr_rd   = 1'b1;
                w.chan_ld = 1'b1;
                w.row_op  = ROW_DEC;
            end
            ST_SCN2: begin
                w.emit    = EMIT_CHAN;
                w.dr_rd   = 1'b1;
                w.chan_ld = 1'b1;
                w.row_op  = ROW_DEC;
                w.cond    = C_CHAN_MORE;
                w.target  = ST_SCN2;
            end
            ST_SCN3: begin
                w.emit     = EMIT_COLW;
                w.scol_adv = 1'b1;
                w.done     = 1'b1;
            end
            ST_RD0: w.fr_rd_cell = 1'b1;
            ST_RD1: begin
                w.emit = EMIT_READ;
                w.done = 1'b1;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lmcs_store.sv =====
// frame and drive intensity stores, one write and one registered read port each
// depends on lmcs_pkg
`default_nettype none

module lmcs_store
    import lmcs_pkg::*;
(
    input  wire logic             aclk,
    input  wire store_req_t       req,
    output logic      [INT_W-1:0] fr_rdata,
    output logic      [INT_W-1:0] dr_rdata
);

    logic [INT_W-1:0] frame_mem [CELLS];
    logic [INT_W-1:0] drive_mem [CELLS];
    logic [INT_W-1:0] fr_rdata_reg;
    logic [INT_W-1:0] dr_rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.fr_we) begin
            frame_mem[req.fr_waddr] <= req.fr_wdata;
        end
        if (req.fr_re) begin
            fr_rdata_reg <= frame_mem[req.fr_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.dr_we) begin
            drive_mem[req.dr_waddr] <= req.dr_wdata;
        end
        if (req.dr_re) begin
            dr_rdata_reg <= drive_mem[req.dr_raddr];
        end
    end

    assign fr_rdata = fr_rdata_reg;
    assign dr_rdata = dr_rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lmcs_seq.sv =====
// microcode sequencer: step counter, control rom lookup, dispatch and conditional jumps
// depends on lmcs_pkg
`default_nettype none

module lmcs_seq
    import lmcs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic [OPER_W-1:0] op,
    input  wire dp_stat_t          stat,
    output logic                   s_ready,
    output logic                   load,
    output ctrl_t                  ctrl
);

    logic [STEP_W-1:0] upc_reg;
    logic [STEP_W-1:0] upc_next;
    ctrl_t             word;
    logic              cond_hit;
    logic              stall;
    logic              idle;

    assign word  = ucode(upc_reg);
    assign idle  = (upc_reg == ST_IDLE);
    assign stall = (word.emit != EMIT_NONE) && stat.out_busy;

    assign s_ready = idle;
    assign load    = idle && s_valid;
    // a stalled step does nothing at all
    assign ctrl    = stall ? ctrl_t'('0) : word;

    always_comb begin
        unique case (word.cond)
            C_NEVER:     cond_hit = 1'b0;
            C_NO_ROWS:   cond_hit = stat.no_rows;
            C_NO_COLS:   cond_hit = stat.no_cols;
            C_NO_RC:     cond_hit = stat.no_rows || stat.no_cols;
            C_ROW_MORE:  cond_hit = !stat.row_last;
            C_COL_MORE:  cond_hit = !stat.col_last;
            C_LIN_MORE:  cond_hit = !stat.lin_last;
            C_CHAN_MORE: cond_hit = stat.chan_more;
            C_PRESENT:   cond_hit = stat.present;
            default:     cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        priority if (idle) begin
            upc_next = load ? entry_step(op) : ST_IDLE;
        end else if (stall) begin
            upc_next = upc_reg;
        end else if (cond_hit) begin
            upc_next = word.target;
        end else if (word.done) begin
            upc_next = ST_IDLE;
        end else begin
            upc_next = upc_reg + STEP_W'(1);
        end
    end

    // reset starts the clearing pass over both stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ST_CLR0;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lmcs_dpath.sv =====
// datapath: row, column and sweep counters, store addressing, copy pipe and result register
// depends on lmcs_pkg; drives lmcs_store requests
`default_nettype none

module lmcs_dpath
    import lmcs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire item_t            item,
    input  wire ctrl_t            ctrl,
    input  wire scan_cfg_t        cfg,
    input  wire logic             m_ready,
    input  wire logic [INT_W-1:0] fr_rdata,
    input  wire logic [INT_W-1:0] dr_rdata,
    output dp_stat_t              stat,
    output store_req_t            req,
    output logic                  m_valid,
    output result_t               result
);

    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [CELL_W-1:0] lin_reg,  lin_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [COL_W-1:0]  scol_reg, scol_next;
    logic [INT_W-1:0]  int_reg,  int_next;
    logic              pres_reg, pres_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              copy_we_reg;
    logic [CELL_W-1:0] copy_addr_reg;
    logic              m_valid_reg, m_valid_next;
    result_t           res_reg, res_next;

    logic              cell_ok;
    logic [CELL_W-1:0] cur_cell;
    logic [CELL_W-1:0] scan_cell;
    logic [COL_W-1:0]  scol_inc;
    logic              wide;
    logic [DATA_W-1:0] col_word;

    assign cell_ok   = row_reg < ROW_W'(MAX_ROWS);
    assign cur_cell  = cell_addr(row_reg, col_reg);
    assign scan_cell = cell_addr(row_reg, scol_reg);

    assign stat.row_last  = row_reg == (cfg.rows - CFG_W'(1));
    assign stat.col_last  = col_reg == COL_W'(cfg.cols - CFG_W'(1));
    assign stat.lin_last  = lin_reg == CELL_W'(CELLS - 1);
    assign stat.chan_more = chan_reg != '0;
    assign stat.no_rows   = cfg.rows == '0;
    assign stat.no_cols   = cfg.cols == '0;
    assign stat.present   = pres_reg;
    assign stat.out_busy  = m_valid_reg && !m_ready;

    // store ports
    always_comb begin
        req.fr_we    = (ctrl.fr_we && cell_ok) || ctrl.clr_we;
        req.fr_waddr = ctrl.clr_we ? lin_reg : cur_cell;
        req.fr_wdata = ctrl.clr_we ? '0 : int_reg;
        req.fr_re    = (ctrl.fr_rd_cell && cell_ok) || ctrl.fr_rd_lin;
        req.fr_raddr = ctrl.fr_rd_lin ? lin_reg : cur_cell;
        // drive store takes the frame read data in the cycle after the copy read
        req.dr_we    = ctrl.clr_we || copy_we_reg;
        req.dr_waddr = ctrl.clr_we ? lin_reg : copy_addr_reg;
        req.dr_wdata = ctrl.clr_we ? '0 : fr_rdata;
        // the read past row zero at the end of a scan is dropped here
        req.dr_re    = ctrl.dr_rd && cell_ok;
        req.dr_raddr = scan_cell;
    end

    always_comb begin
        if (load) begin
            row_next = item.row_index;
        end else begin
            unique case (ctrl.row_op)
                ROW_HOLD: row_next = row_reg;
                ROW_ZERO: row_next = '0;
                ROW_INC:  row_next = row_reg + ROW_W'(1);
                ROW_DEC:  row_next = row_reg - ROW_W'(1);
                ROW_TOP:  row_next = cfg.rows - CFG_W'(1);
                default:  row_next = row_reg;
            endcase
        end
    end

    always_comb begin
        if (load) begin
            col_next = item.col_index;
        end else begin
            unique case (ctrl.col_op)
                COL_HOLD: col_next = col_reg;
                COL_ZERO: col_next = '0;
                COL_INC:  col_next = col_reg + COL_W'(1);
                default:  col_next = col_reg;
            endcase
        end
    end

    always_comb begin
        unique case (ctrl.lin_op)
            LIN_HOLD: lin_next = lin_reg;
            LIN_ZERO: lin_next = '0;
            LIN_INC:  lin_next = lin_reg + CELL_W'(1);
            default:  lin_next = lin_reg;
        endcase
    end

    assign chan_next  = ctrl.chan_ld ? row_reg : chan_reg;
    assign int_next   = load ? item.intensity : int_reg;
    assign pres_next  = load ? item.present_after : pres_reg;
    assign rd_ok_next = ctrl.fr_rd_cell ? cell_ok : rd_ok_reg;

    // column word and column counter
    assign wide     = cfg.cols > NARROW_COLS;
    assign col_word = (COLW_ONE << scol_reg) & (wide ? WIDE_MASK : NARROW_MASK);
    assign scol_inc = scol_reg + COL_W'(1);

    always_comb begin
        scol_next = scol_reg;
        if (ctrl.scol_adv) begin
            scol_next = ({1'b0, scol_inc} >= cfg.cols) ? '0 : scol_inc;
        end
    end

    // result register
    always_comb begin
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (ctrl.emit)
            EMIT_NONE: ;
            EMIT_CHAN: begin
                m_valid_next              = 1'b1;
                res_next.kind             = KIND_CHAN;
                res_next.channel          = chan_reg;
                res_next.data_word        = DATA_W'(dr_rdata);
                res_next.column_word_bits = '0;
                res_next.last             = 1'b0;
            end
            EMIT_COLW: begin
                m_valid_next              = 1'b1;
                res_next.kind             = KIND_COLW;
                res_next.channel          = '0;
                res_next.data_word        = col_word;
                res_next.column_word_bits = wide ? COLW_WIDE : COLW_NARROW;
                res_next.last             = 1'b1;
            end
            EMIT_READ: begin
                m_valid_next              = 1'b1;
                res_next.kind             = KIND_READ;
                res_next.channel          = '0;
                res_next.data_word        = rd_ok_reg ? DATA_W'(fr_rdata) : '0;
                res_next.column_word_bits = '0;
                res_next.last             = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scol_reg    <= '0;
            copy_we_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            scol_reg    <= scol_next;
            copy_we_reg <= ctrl.fr_rd_lin;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        lin_reg       <= lin_next;
        chan_reg      <= chan_next;
        int_reg       <= int_next;
        pres_reg      <= pres_next;
        rd_ok_reg     <= rd_ok_next;
        copy_addr_reg <= lin_reg;
        res_reg       <= res_next;
    end

    assign m_valid = m_valid_reg;
    assign result  = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/led_matrix_column_scanner_unit.sv =====
// top level of the led matrix column scanner: config registers, stream ports and wiring
// depends on lmcs_pkg, lmcs_seq, lmcs_dpath and lmcs_store
`default_nettype none

// Multiplexed LED matrix scan driver with a 24 x 16 frame store and a matching drive
// store of 12-bit intensities. Set pixel, row, column or whole frame edit the frame
// store; present copies it into the drive store; a scan tick sends the drive-store
// intensities of the current column from the highest row in use down to row 0, then
// a one-hot column word of 8 or 16 bits, and advances the column. Read pixel returns
// one frame-store intensity. A microcoded sequencer runs one item at a time and takes
// the next item only after the previous one's program ends. Set all also presents
// afterwards when present_after is set; present does one frame-store read and one
// drive-store write per cell. A step that emits a result stalls while the previous
// result still waits for its output transfer. After reset both stores are cleared
// one cell a cycle, and s_tready stays low until the clearing pass ends;
// configuration writes are taken at any time.
module led_matrix_column_scanner_unit
    import lmcs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // row_index, col_index, intensity,
                                                // present_after, zero pad
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // operation
    // results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // channel, data_word, column_word_bits,
                                                // zero pad
    output logic [M_TUSER_W-1:0]      m_tuser,  // kind
    output logic                      m_tlast
);

    logic [CFG_W-1:0] num_rows_reg, num_rows_next;
    logic [CFG_W-1:0] num_cols_reg, num_cols_next;
    scan_cfg_t        cfg;
    item_t            item;
    ctrl_t            ctrl;
    dp_stat_t         stat;
    store_req_t       req;
    result_t          result;
    logic             load;
    logic [INT_W-1:0] fr_rdata;
    logic [INT_W-1:0] dr_rdata;

    always_comb begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_NUM_ROWS: num_rows_next = cfg_wdata;
                REG_NUM_COLS: num_cols_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= NUM_ROWS_RST;
            num_cols_reg <= NUM_COLS_RST;
        end else begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
        end
    end

    // counts above the store size use the whole store
    assign cfg.rows = (num_rows_reg > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : num_rows_reg;
    assign cfg.cols = (num_cols_reg > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : num_cols_reg;

    assign item.row_index     = s_tdata[ROW_W-1:0];
    assign item.col_index     = s_tdata[ROW_W +: COL_W];
    assign item.intensity     = s_tdata[ROW_W+COL_W +: INT_W];
    assign item.present_after = s_tdata[ROW_W+COL_W+INT_W];

    lmcs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .op      (s_tuser),
        .stat    (stat),
        .s_ready (s_tready),
        .load    (load),
        .ctrl    (ctrl)
    );

    lmcs_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .item     (item),
        .ctrl     (ctrl),
        .cfg      (cfg),
        .m_ready  (m_tready),
        .fr_rdata (fr_rdata),
        .dr_rdata (dr_rdata),
        .stat     (stat),
        .req      (req),
        .m_valid  (m_tvalid),
        .result   (result)
    );

    lmcs_store u_store (
        .aclk     (aclk),
        .req      (req),
        .fr_rdata (fr_rdata),
        .dr_rdata (dr_rdata)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, result.column_word_bits, result.data_word,
                      result.channel};
    assign m_tuser = result.kind;
    assign m_tlast = result.last;

endmodule

`default_nettype wire
